[src/hss_pkg.sv]
// ----------------------------------------------------------------------------
// hss_pkg
// Shared types, constants and hash step functions for the signature scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package hss_pkg;

  localparam int BUFFER_DEPTH = 65536;
  localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
  localparam int COUNT_W      = ADDR_W + 1;
  localparam int OFFSET_W     = 16;
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 32;

  localparam logic [31:0] FNV_BASIS = 32'h811C9DC5;
  localparam logic [31:0] FNV_PRIME = 32'h01000193;
  localparam logic [31:0] OAT_SEED  = 32'h04C11DB7;

  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_BYTE = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIG_LENGTH = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIG_HASH   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HASH_MODE  = 8'd3;

  localparam logic MODE_FNV = 1'b0;
  localparam logic MODE_OAT = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] match_offset;
    logic                overflowed;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  first_byte;
    logic [7:0]  sig_length;
    logic [31:0] sig_hash;
    logic        hash_mode;
  } cfg_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [7:0]        wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic init;
    logic step;
    logic fin;
  } hash_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_CHECK,
    S_HASH_RD,
    S_HASH_UP,
    S_FINAL,
    S_CMP,
    S_DONE
  } scan_state_t;

  function automatic logic [31:0] fnv_step(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] x;
    x = h ^ {24'h0, b};
    return 32'(x * FNV_PRIME);
  endfunction

  function automatic logic [31:0] oat_step(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] t;
    t = h + {24'h0, b};
    t = t + (t << 10);
    t = t ^ (t >> 6);
    return t;
  endfunction

  function automatic logic [31:0] oat_final(input logic [31:0] h);
    logic [31:0] t;
    t = h + (h << 3);
    t = t ^ (t >> 11);
    t = t + (t << 15);
    return t;
  endfunction

endpackage

`default_nettype wire

[src/hss_byte_ram.sv]
// ----------------------------------------------------------------------------
// hss_byte_ram
// Buffer store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hss_byte_ram (
  input  wire logic              clk,
  input  wire hss_pkg::ram_req_t req,
  output logic [7:0]             rdata_r
);

  logic [7:0] mem [hss_pkg::BUFFER_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

endmodule

`default_nettype wire

[src/hss_hash_unit.sv]
// ----------------------------------------------------------------------------
// hss_hash_unit
// Running window hash: seed, one byte per step, optional finalize.
// ----------------------------------------------------------------------------
`default_nettype none

module hss_hash_unit (
  input  wire logic               clk,
  input  wire logic               mode,
  input  wire hss_pkg::hash_cmd_t cmd,
  input  wire logic [7:0]         data,
  output logic [31:0]             hash_r
);

  logic [31:0] hash_nxt;

  always_comb begin
    hash_nxt = hash_r;
    if (cmd.init) begin
      hash_nxt = (mode == hss_pkg::MODE_OAT) ? hss_pkg::OAT_SEED : hss_pkg::FNV_BASIS;
    end else if (cmd.step) begin
      hash_nxt = (mode == hss_pkg::MODE_OAT) ? hss_pkg::oat_step(hash_r, data)
                                             : hss_pkg::fnv_step(hash_r, data);
    end else if (cmd.fin && (mode == hss_pkg::MODE_OAT)) begin
      hash_nxt = hss_pkg::oat_final(hash_r);
    end
  end

  always_ff @(posedge clk) begin
    hash_r <= hash_nxt;
  end

endmodule

`default_nettype wire

[src/hss_scan_ctrl.sv]
// ----------------------------------------------------------------------------
// hss_scan_ctrl
// Load sequencer and scan FSM: stores bytes, walks offsets, drives hashing.
// ----------------------------------------------------------------------------
`default_nettype none

module hss_scan_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire hss_pkg::in_item_t  in_data,
  input  wire hss_pkg::cfg_t      cfg,
  input  wire logic [7:0]         rdata,
  input  wire logic [31:0]        hash,
  output logic                    busy,
  output hss_pkg::ram_req_t       ram_req,
  output hss_pkg::hash_cmd_t      hash_cmd,
  output logic                    out_strobe,
  output hss_pkg::out_item_t      out_data
);

  localparam int W = hss_pkg::COUNT_W;

  hss_pkg::scan_state_t          state_r, state_nxt;
  logic [W-1:0]                  count_r, count_nxt;
  logic [W-1:0]                  pos_r, pos_nxt;
  logic [7:0]                    widx_r, widx_nxt;
  logic                          ovf_r, ovf_nxt;
  logic                          found_r, found_nxt;
  logic [hss_pkg::OFFSET_W-1:0]  offset_r, offset_nxt;
  logic [W:0]                    win_end;
  logic [W-1:0]                  rd_pos;

  assign win_end = {1'b0, pos_r} + (W+1)'(cfg.sig_length);
  assign rd_pos  = pos_r + W'(widx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hss_pkg::S_IDLE;
      count_r <= '0;
      pos_r   <= '0;
      widx_r  <= '0;
      ovf_r   <= 1'b0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pos_r   <= pos_nxt;
      widx_r  <= widx_nxt;
      ovf_r   <= ovf_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    offset_r <= offset_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    widx_nxt      = widx_r;
    ovf_nxt       = ovf_r;
    found_nxt     = found_r;
    offset_nxt    = offset_r;
    ram_req.we    = 1'b0;
    ram_req.waddr = count_r[hss_pkg::ADDR_W-1:0];
    ram_req.wdata = in_data.data_byte;
    ram_req.raddr = pos_r[hss_pkg::ADDR_W-1:0];
    hash_cmd      = '0;
    busy          = 1'b1;
    out_strobe    = 1'b0;

    case (state_r)
      hss_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (count_r < W'(hss_pkg::BUFFER_DEPTH)) begin
            ram_req.we = 1'b1;
            count_nxt  = count_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_data.last_byte) begin
            pos_nxt   = '0;
            state_nxt = hss_pkg::S_FETCH;
          end
        end
      end
      hss_pkg::S_FETCH: begin
        if (pos_r == count_r) begin
          found_nxt  = 1'b0;
          offset_nxt = '0;
          state_nxt  = hss_pkg::S_DONE;
        end else begin
          state_nxt = hss_pkg::S_CHECK;
        end
      end
      hss_pkg::S_CHECK: begin
        if ((rdata == cfg.first_byte) && (win_end <= {1'b0, count_r})) begin
          hash_cmd.init = 1'b1;
          widx_nxt      = '0;
          state_nxt     = (cfg.sig_length == 8'd0) ? hss_pkg::S_FINAL : hss_pkg::S_HASH_RD;
        end else begin
          pos_nxt   = pos_r + 1'b1;
          state_nxt = hss_pkg::S_FETCH;
        end
      end
      hss_pkg::S_HASH_RD: begin
        ram_req.raddr = rd_pos[hss_pkg::ADDR_W-1:0];
        state_nxt     = hss_pkg::S_HASH_UP;
      end
      hss_pkg::S_HASH_UP: begin
        hash_cmd.step = 1'b1;
        if ({1'b0, widx_r} + 9'd1 == {1'b0, cfg.sig_length}) begin
          state_nxt = hss_pkg::S_FINAL;
        end else begin
          widx_nxt  = widx_r + 1'b1;
          state_nxt = hss_pkg::S_HASH_RD;
        end
      end
      hss_pkg::S_FINAL: begin
        hash_cmd.fin = 1'b1;
        state_nxt    = hss_pkg::S_CMP;
      end
      hss_pkg::S_CMP: begin
        if (hash == cfg.sig_hash) begin
          found_nxt  = 1'b1;
          offset_nxt = hss_pkg::OFFSET_W'(pos_r);
          state_nxt  = hss_pkg::S_DONE;
        end else begin
          pos_nxt   = pos_r + 1'b1;
          state_nxt = hss_pkg::S_FETCH;
        end
      end
      hss_pkg::S_DONE: begin
        out_strobe = 1'b1;
        count_nxt  = '0;
        pos_nxt    = '0;
        widx_nxt   = '0;
        ovf_nxt    = 1'b0;
        state_nxt  = hss_pkg::S_IDLE;
      end
      default: begin
        state_nxt = hss_pkg::S_IDLE;
      end
    endcase
  end

  assign out_data.found        = found_r;
  assign out_data.match_offset = offset_r;
  assign out_data.overflowed   = ovf_r;

endmodule

`default_nettype wire

[src/hashed_signature_scanner_top.sv]
// ----------------------------------------------------------------------------
// hashed_signature_scanner_top
// Byte buffer loader and hashed signature search (FNV-1a or seeded OAT).
// ----------------------------------------------------------------------------
// channel  | handshake                  | payload
// input    | start, busy                | in_data  (data_byte, last_byte)
// result   | out_strobe                 | out_data (found, match_offset, overflowed)
// config   | cfg_valid, cfg_ready       | cfg_index, cfg_data
//
// Load: one byte per cycle while busy is low; the last byte raises busy.
// Scan: FETCH and CHECK per offset; a candidate that passes the first-byte and fit
// checks adds HASH_RD, HASH_UP per byte, then FINAL, CMP; all reads use one RAM.
// Result: out_strobe for one cycle, then busy drops and the next buffer loads.
// The receiver cannot stall results; only the scan holds off new requests.
// Reset clears control state only; the buffer RAM is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module hashed_signature_scanner_top (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire hss_pkg::in_item_t                 in_data,
  output logic                                   out_strobe,
  output hss_pkg::out_item_t                     out_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [hss_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [hss_pkg::CFG_DATA_W-1:0]    cfg_data
);

  hss_pkg::cfg_t      cfg_r;
  hss_pkg::ram_req_t  ram_req;
  hss_pkg::hash_cmd_t hash_cmd;
  logic [7:0]         rdata;
  logic [31:0]        hash;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hss_pkg::CFG_FIRST_BYTE: cfg_r.first_byte <= cfg_data[7:0];
        hss_pkg::CFG_SIG_LENGTH: cfg_r.sig_length <= cfg_data[7:0];
        hss_pkg::CFG_SIG_HASH:   cfg_r.sig_hash   <= cfg_data[31:0];
        hss_pkg::CFG_HASH_MODE:  cfg_r.hash_mode  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  hss_byte_ram u_ram (
    .clk     (clk),
    .req     (ram_req),
    .rdata_r (rdata)
  );

  hss_hash_unit u_hash (
    .clk    (clk),
    .mode   (cfg_r.hash_mode),
    .cmd    (hash_cmd),
    .data   (rdata),
    .hash_r (hash)
  );

  hss_scan_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_data    (in_data),
    .cfg        (cfg_r),
    .rdata      (rdata),
    .hash       (hash),
    .busy       (busy),
    .ram_req    (ram_req),
    .hash_cmd   (hash_cmd),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  a_last_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.last_byte) |=> busy)
    else $error("busy not raised after last byte");

  a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !busy)
    else $error("busy still high after result");

  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result strobe outside scan");

  a_miss_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_data.found) |-> (out_data.match_offset == '0))
    else $error("nonzero offset on miss");

endmodule

`default_nettype wire
